// ===== rtl/npsch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsch_pkg
// Shared types and constants of the note preview scheduler.
// ----------------------------------------------------------------------------
package npsch_pkg;

  localparam int NPSCH_SLOTS = 16;

  localparam int REQ_W   = 2;
  localparam int CHAN_W  = 5;
  localparam int SCH_W   = 4;
  localparam int KEY_W   = 8;
  localparam int VEL_W   = 7;
  localparam int HOLD_W  = 15;
  localparam int REM_W   = 17;
  localparam int TICK_W  = 10;
  localparam int KIND_W  = 2;

  localparam logic [TICK_W-1:0] TICK_MS_RESET = 10'd10;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PREVIEW = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL  = 2'd2;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] EV_FULL     = 2'd2;
  localparam logic [KIND_W-1:0] EV_NONE     = 2'd3;

  typedef struct packed {
    logic              used;
    logic [KEY_W-1:0]  key;
    logic [SCH_W-1:0]  chan;
    logic [VEL_W-1:0]  vel;
    logic              on_pend;
    logic [REM_W-1:0]  rem;
  } slot_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  vel;
  } event_t;

  // Controls handed from the sequencer to the slot update unit.
  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic              sel;
    logic              hit_mode;
    logic              send_offs;
  } proc_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  function automatic logic [CHAN_W-1:0] chan_out(input logic [SCH_W-1:0] c);
    chan_out = {1'b0, c} + 5'd1;
  endfunction

endpackage

// ===== rtl/npsch_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsch_cell
// One table entry of the slot ring; shifts toward its neighbor on enable.
// ----------------------------------------------------------------------------
module npsch_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift_en,
  input  npsch_pkg::slot_t           d,
  input  logic [npsch_pkg::KEY_W-1:0] cmp_key,
  input  logic [npsch_pkg::SCH_W-1:0] cmp_chan,
  output npsch_pkg::slot_t           q,
  output logic                       hit,
  output logic                       free
);
  import npsch_pkg::*;

  slot_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.used    <= 1'b0;
      st.on_pend <= 1'b0;
      st.rem     <= '0;
    end else if (shift_en) begin
      st <= d;
    end
  end

  assign q    = st;
  assign hit  = st.used && (st.key == cmp_key) && (st.chan == cmp_chan);
  assign free = !st.used;

endmodule

// ===== rtl/npsch_proc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsch_proc
// Updates the entry at the head of the ring and forms the event it causes.
// ----------------------------------------------------------------------------
module npsch_proc (
  input  npsch_pkg::slot_t             head,
  input  npsch_pkg::proc_ctl_t         ctl,
  input  logic [npsch_pkg::SCH_W-1:0]  rq_chan,
  input  logic [npsch_pkg::KEY_W-1:0]  rq_key,
  input  logic [npsch_pkg::VEL_W-1:0]  rq_vel,
  input  logic [npsch_pkg::HOLD_W-1:0] rq_hold,
  input  logic [npsch_pkg::TICK_W-1:0] tick_ms,
  output npsch_pkg::slot_t             nxt,
  output logic                         ev_valid,
  output npsch_pkg::event_t            ev
);
  import npsch_pkg::*;

  logic              sounding;
  logic [REM_W-1:0]  step;
  logic [REM_W-1:0]  rem_dec;

  always_comb begin
    sounding = head.used && !head.on_pend && (head.rem != '0);
    step     = (tick_ms == '0) ? REM_W'(1) : REM_W'(tick_ms);
    rem_dec  = (head.rem > step) ? (head.rem - step) : '0;

    nxt      = head;
    ev_valid = 1'b0;
    ev.kind  = EV_NOTE_OFF;
    ev.chan  = chan_out(head.chan);
    ev.key   = head.key;
    ev.vel   = '0;

    case (ctl.op)
      REQ_PREVIEW: begin
        if (ctl.sel) begin
          if (ctl.hit_mode) begin
            ev_valid = sounding;
          end else begin
            nxt.used = 1'b1;
            nxt.key  = rq_key;
            nxt.chan = rq_chan;
          end
          nxt.vel     = rq_vel;
          nxt.on_pend = 1'b1;
          nxt.rem     = REM_W'(rq_hold);
        end
      end
      REQ_TICK: begin
        if (head.used) begin
          if (head.on_pend) begin
            nxt.on_pend = 1'b0;
            ev_valid    = 1'b1;
            ev.kind     = EV_NOTE_ON;
            ev.vel      = head.vel;
            if (head.rem == '0) nxt.used = 1'b0;
          end else if (head.rem != '0) begin
            nxt.rem = rem_dec;
            if (rem_dec == '0) begin
              ev_valid = 1'b1;
              nxt.used = 1'b0;
            end
          end else begin
            nxt.used = 1'b0;
          end
        end
      end
      REQ_CANCEL: begin
        ev_valid    = ctl.send_offs && sounding;
        nxt.used    = 1'b0;
        nxt.on_pend = 1'b0;
        nxt.rem     = '0;
      end
      default: begin
        nxt = head;
      end
    endcase
  end

endmodule

// ===== rtl/note_preview_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_preview_scheduler_core
// Note preview table built as a ring of slot cells with one update unit.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  request   in         in_valid / in_stall   req_type channel key velocity
//                                             hold_ms send_offs
//  events    out        out_valid / out_stall event_kind out_channel out_key
//                                             out_velocity last
//  config    in         cfg_valid / cfg_ready cfg_data (tick_ms)
//
// Each item is accepted, then the ring rotates past the update unit slot by
// slot, then the final event is emitted. A stalled output holds the ring when
// a new event finds no room. Reset clears the table at once; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module note_preview_scheduler_core #(
  parameter int SLOTS = npsch_pkg::NPSCH_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [npsch_pkg::REQ_W-1:0]   req_type,
  input  logic [npsch_pkg::CHAN_W-1:0]  channel,
  input  logic [npsch_pkg::KEY_W-1:0]   key,
  input  logic [npsch_pkg::VEL_W-1:0]   velocity,
  input  logic [npsch_pkg::HOLD_W-1:0]  hold_ms,
  input  logic                          send_offs,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [npsch_pkg::KIND_W-1:0]  event_kind,
  output logic [npsch_pkg::CHAN_W-1:0]  out_channel,
  output logic [npsch_pkg::KEY_W-1:0]   out_key,
  output logic [npsch_pkg::VEL_W-1:0]   out_velocity,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [npsch_pkg::TICK_W-1:0]  cfg_data
);
  import npsch_pkg::*;

  localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state, state_next;

  logic [TICK_W-1:0] tick_ms;
  logic [REQ_W-1:0]  op;
  logic [SCH_W-1:0]  rq_chan;
  logic [KEY_W-1:0]  rq_key;
  logic [VEL_W-1:0]  rq_vel;
  logic [HOLD_W-1:0] rq_hold;
  logic              rq_offs;
  logic              hit_mode;
  logic [SLOTS-1:0]  sel;
  logic [CW-1:0]     cnt;

  event_t pend;
  logic   pend_valid;
  event_t out_ev;
  logic   out_last;

  slot_t            cell_q [SLOTS];
  slot_t            tail_d;
  logic [SLOTS-1:0] hit_vec;
  logic [SLOTS-1:0] free_vec;
  logic [SLOTS-1:0] hit_first;
  logic [SLOTS-1:0] free_first;
  logic [SCH_W-1:0] in_chan4;

  proc_ctl_t ctl;
  event_t    ev;
  event_t    none_ev;
  event_t    full_ev;
  logic      ev_valid;
  logic      accept;
  logic      out_free;
  logic      step_ok;
  logic      scan_end;
  logic      flush_ok;
  logic      out_load;

  assign in_chan4 = SCH_W'(channel - 5'd1);

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      slot_t d_in;
      if (g == SLOTS - 1) begin : g_tail
        assign d_in = tail_d;
      end else begin : g_mid
        assign d_in = cell_q[g+1];
      end
      npsch_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (step_ok),
        .d        (d_in),
        .cmp_key  (key),
        .cmp_chan (in_chan4),
        .q        (cell_q[g]),
        .hit      (hit_vec[g]),
        .free     (free_vec[g])
      );
    end
  endgenerate

  // Lowest set bit of each vector.
  assign hit_first  = hit_vec & (~hit_vec + SLOTS'(1));
  assign free_first = free_vec & (~free_vec + SLOTS'(1));

  assign ctl.op        = op;
  assign ctl.sel       = sel[cnt];
  assign ctl.hit_mode  = hit_mode;
  assign ctl.send_offs = rq_offs;

  npsch_proc u_proc (
    .head     (cell_q[0]),
    .ctl      (ctl),
    .rq_chan  (rq_chan),
    .rq_key   (rq_key),
    .rq_vel   (rq_vel),
    .rq_hold  (rq_hold),
    .tick_ms  (tick_ms),
    .nxt      (tail_d),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  always_comb begin
    none_ev.kind = EV_NONE;
    none_ev.chan = '0;
    none_ev.key  = '0;
    none_ev.vel  = '0;
    full_ev.kind = EV_FULL;
    full_ev.chan = chan_out(in_chan4);
    full_ev.key  = key;
    full_ev.vel  = '0;
  end

  // Control outputs.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    cfg_ready = 1'b1;
    accept    = (state == ST_IDLE) && in_valid;
    out_free  = !out_valid || !out_stall;
    step_ok   = (state == ST_SCAN) && !(ev_valid && pend_valid && !out_free);
    scan_end  = step_ok && (cnt == CW'(SLOTS - 1));
    flush_ok  = (state == ST_FLUSH) && out_free;
    out_load  = (step_ok && ev_valid && pend_valid) || flush_ok;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SCAN;
      ST_SCAN:  if (scan_end) state_next = ST_FLUSH;
      ST_FLUSH: if (flush_ok) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_ms    <= TICK_MS_RESET;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) tick_ms <= cfg_data;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Only a preview request can report a full table.
      if (accept) begin
        cnt        <= '0;
        pend_valid <= (req_type == REQ_PREVIEW) && (hit_vec == '0) && (free_vec == '0);
      end

      if (step_ok) begin
        cnt <= cnt + CW'(1);
        if (ev_valid) pend_valid <= 1'b1;
      end

      if (flush_ok) pend_valid <= 1'b0;
    end
  end

  // Request latch and event payloads.
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req_type;
      rq_chan  <= in_chan4;
      rq_key   <= key;
      rq_vel   <= velocity;
      rq_hold  <= hold_ms;
      rq_offs  <= send_offs;
      hit_mode <= (hit_vec != '0);
      sel      <= (hit_vec != '0) ? hit_first : free_first;
      pend     <= full_ev;
    end
    if (step_ok && ev_valid) begin
      pend <= ev;
      if (pend_valid) begin
        out_ev   <= pend;
        out_last <= 1'b0;
      end
    end
    if (flush_ok) begin
      out_ev   <= pend_valid ? pend : none_ev;
      out_last <= 1'b1;
    end
  end

  assign event_kind   = out_ev.kind;
  assign out_channel  = out_ev.chan;
  assign out_key      = out_ev.key;
  assign out_velocity = out_ev.vel;
  assign last         = out_last;

endmodule

// ===== rtl/npsch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npsch_checker
// Port-level checks of the note preview scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module npsch_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [npsch_pkg::KIND_W-1:0]  event_kind,
  input logic [npsch_pkg::CHAN_W-1:0]  out_channel,
  input logic [npsch_pkg::KEY_W-1:0]   out_key,
  input logic [npsch_pkg::VEL_W-1:0]   out_velocity,
  input logic                          last
);
  import npsch_pkg::*;

  // A stalled event holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) &&
      $stable(out_channel) && $stable(out_key) && $stable(out_velocity) &&
      $stable(last))
    else $error("stalled output event changed");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous item in work");

  // The empty result always closes its item.
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_NONE |-> last && out_velocity == '0 &&
      out_key == '0 && out_channel == '0)
    else $error("empty result malformed");

  // Note-offs and table-full results carry no velocity and a valid channel.
  a_off_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EV_NOTE_OFF || event_kind == EV_FULL) |->
      out_velocity == '0 && out_channel != '0)
    else $error("note-off or table-full result malformed");

endmodule

bind note_preview_scheduler_core npsch_checker u_npsch_checker (.*);
